FILE: sv/pqsr_pkg.sv
// ----------------------------------------------------------------------------
// pqsr_pkg
// shared types and constants for the preamble-qualified serial receiver
// ----------------------------------------------------------------------------
package pqsr_pkg;

   localparam int DATA_BITS_DEFAULT = 9;
   localparam int TICK_W            = 16;
   localparam int VALUE_W           = 9;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_ADDR_W        = 4;
   localparam int CSR_IDX_W         = 2;

   localparam logic [TICK_W-1:0]  PREAMBLE_RESET = 16'd200;
   localparam logic [TICK_W-1:0]  OFFSET_RESET   = 16'd75;
   localparam logic [TICK_W-1:0]  PERIOD_RESET   = 16'd100;
   localparam logic [VALUE_W-1:0] LIMIT_RESET    = 9'd511;

   // register indexes (byte address is 4 * index)
   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT    = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_QUALIFY = 3'd1,
      PH_WAITLOW = 3'd2,
      PH_OFFSET  = 3'd3,
      PH_BITS    = 3'd4
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0]  preamble_ticks;
      logic [TICK_W-1:0]  sample_offset_ticks;
      logic [TICK_W-1:0]  bit_period_ticks;
      logic [VALUE_W-1:0] value_limit;
   } config_type;

   typedef struct packed {
      logic               emit;
      logic [VALUE_W-1:0] received_value;
      logic               was_clamped;
   } result_type;

endpackage

FILE: sv/pqsr_csr.sv
// ----------------------------------------------------------------------------
// pqsr_csr
// configuration registers behind a simple apb-style port
// ----------------------------------------------------------------------------
module pqsr_csr
   import pqsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output config_type            cfg
);

   config_type             cfg_ff;
   config_type             cfg_in;
   logic [CSR_IDX_W-1:0]   index;
   logic                   write_en;

   assign pready   = 1'b1;
   assign index    = paddr[CSR_ADDR_W-1:2];
   assign write_en = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            CSR_PREAMBLE: cfg_in.preamble_ticks      = pwdata[TICK_W-1:0];
            CSR_OFFSET:   cfg_in.sample_offset_ticks = pwdata[TICK_W-1:0];
            CSR_PERIOD:   cfg_in.bit_period_ticks    = pwdata[TICK_W-1:0];
            CSR_LIMIT:    cfg_in.value_limit         = pwdata[VALUE_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_ticks      <= PREAMBLE_RESET;
         cfg_ff.sample_offset_ticks <= OFFSET_RESET;
         cfg_ff.bit_period_ticks    <= PERIOD_RESET;
         cfg_ff.value_limit         <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         CSR_PREAMBLE: prdata = CSR_DATA_W'(cfg_ff.preamble_ticks);
         CSR_OFFSET:   prdata = CSR_DATA_W'(cfg_ff.sample_offset_ticks);
         CSR_PERIOD:   prdata = CSR_DATA_W'(cfg_ff.bit_period_ticks);
         CSR_LIMIT:    prdata = CSR_DATA_W'(cfg_ff.value_limit);
         default:      prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/pqsr_fsm.sv
// ----------------------------------------------------------------------------
// pqsr_fsm
// frame state machine: preamble check, start detect, bit sampling, clamp
// ----------------------------------------------------------------------------
module pqsr_fsm
   import pqsr_pkg::*;
#(
   parameter int DATA_BITS = DATA_BITS_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       level,
   input  config_type cfg,
   output logic       emit_due,
   output result_type result
);

   localparam int BIT_IDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
   localparam int CMP_W     = (DATA_BITS > VALUE_W) ? DATA_BITS : VALUE_W;
   localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(DATA_BITS - 1);

   phase_type               phase_ff, phase_in;
   logic [TICK_W-1:0]       tick_ff, tick_in;
   logic [BIT_IDX_W-1:0]    bit_index_ff, bit_index_in;
   logic [DATA_BITS-1:0]    shift_ff, shift_in;
   logic                    prev_level_ff, prev_level_in;

   logic [TICK_W-1:0]       tick_next;
   logic [TICK_W-1:0]       period_sel;
   logic                    expired;
   logic                    last_bit;
   logic [BIT_IDX_W-1:0]    bit_next;
   logic [CMP_W-1:0]        raw_ext;
   logic [CMP_W-1:0]        limit_ext;
   logic                    over_limit;

   // shared tick counter, period picked by phase
   always_comb begin
      unique case (phase_ff)
         PH_QUALIFY: period_sel = cfg.preamble_ticks;
         PH_OFFSET:  period_sel = cfg.sample_offset_ticks;
         default:    period_sel = cfg.bit_period_ticks;
      endcase
   end

   assign tick_next  = tick_ff + TICK_W'(1);
   assign expired    = (tick_next >= period_sel) || (tick_next == '0);
   assign last_bit   = (bit_index_ff == LAST_BIT);
   assign bit_next   = bit_index_ff + BIT_IDX_W'(1);
   assign emit_due   = (phase_ff == PH_BITS) && expired && last_bit;

   assign raw_ext    = CMP_W'(shift_ff);
   assign limit_ext  = CMP_W'(cfg.value_limit);
   assign over_limit = raw_ext > limit_ext;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (level && !prev_level_ff) phase_in = PH_QUALIFY;
         end
         PH_QUALIFY: begin
            if (!level)       phase_in = PH_IDLE;
            else if (expired) phase_in = PH_WAITLOW;
         end
         PH_WAITLOW: begin
            if (!level) phase_in = PH_OFFSET;
         end
         PH_OFFSET: begin
            if (expired) phase_in = PH_BITS;
         end
         PH_BITS: begin
            if (expired && last_bit) phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // counters, shift register and result
   always_comb begin
      tick_in               = tick_ff;
      bit_index_in          = bit_index_ff;
      shift_in              = shift_ff;
      prev_level_in         = level;
      result.emit           = 1'b0;
      result.was_clamped    = over_limit;
      result.received_value = over_limit ? cfg.value_limit : raw_ext[VALUE_W-1:0];
      unique case (phase_ff)
         PH_IDLE: begin
            if (level && !prev_level_ff) tick_in = '0;
         end
         PH_QUALIFY: begin
            if (level) tick_in = expired ? '0 : tick_next;
         end
         PH_WAITLOW: begin
            if (!level) begin
               tick_in  = '0;
               shift_in = '0;
            end
         end
         PH_OFFSET: begin
            tick_in = expired ? '0 : tick_next;
            if (expired) begin
               bit_index_in = '0;
               shift_in[0]  = level;
            end
         end
         PH_BITS: begin
            tick_in = expired ? '0 : tick_next;
            if (expired) begin
               if (!last_bit) begin
                  bit_index_in       = bit_next;
                  shift_in[bit_next] = level;
               end else begin
                  result.emit = 1'b1;
               end
            end
         end
         default: begin
            tick_in = tick_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_ff       <= '0;
         bit_index_ff  <= '0;
         shift_ff      <= '0;
         prev_level_ff <= 1'b1;
      end else if (accept) begin
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         bit_index_ff  <= bit_index_in;
         shift_ff      <= shift_in;
         prev_level_ff <= prev_level_in;
      end
   end

endmodule

FILE: sv/preamble_qualified_serial_receiver_core.sv
// ----------------------------------------------------------------------------
// preamble_qualified_serial_receiver_core
// serial line receiver with preamble qualification and value clamping
// ----------------------------------------------------------------------------
// Each request carries one sample of the serial line. A rising edge while idle
// starts qualification; the line must then stay high for preamble_ticks
// samples, and a low sample drops back to idle. The block then waits for a low
// start level, counts sample_offset_ticks to bit 0 and takes DATA_BITS bits,
// lsb first, bit_period_ticks apart. One bit period after the last bit the
// value is clamped to value_limit and a single response is issued with a flag
// telling whether clamping happened. A timing register written as zero acts
// as one. One request is taken every clock: the frame state is registered from
// the sample, and the response sits in an output register so further samples
// keep flowing while it waits. req_stall is raised only when a response is
// still held under rsp_stall and the current sample would finish the next
// frame. Configuration is written via the apb-style port with pready tied high;
// the user must do so only while no frame is in progress (not enforced).
// ----------------------------------------------------------------------------
module preamble_qualified_serial_receiver_core
   import pqsr_pkg::*;
#(
   parameter int DATA_BITS = DATA_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   // sample requests
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_line_level,
   // frame responses
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_W-1:0]    rsp_received_value,
   output logic                  rsp_was_clamped,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   config_type          cfg;
   result_type          result;
   logic                emit_due;
   logic                req_accept;
   logic                rsp_taken;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_clamped_ff, rsp_clamped_in;

   pqsr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pqsr_fsm #(
      .DATA_BITS (DATA_BITS)
   ) u_fsm (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .level    (req_line_level),
      .cfg      (cfg),
      .emit_due (emit_due),
      .result   (result)
   );

   // the response slot frees up in the same cycle it is taken
   assign rsp_taken  = rsp_valid_ff && !rsp_stall;
   assign req_stall  = emit_due && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_taken;
      rsp_value_in   = rsp_value_ff;
      rsp_clamped_in = rsp_clamped_ff;
      if (req_accept && result.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_value_in   = result.received_value;
         rsp_clamped_in = result.was_clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff   <= rsp_value_in;
      rsp_clamped_ff <= rsp_clamped_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_received_value = rsp_value_ff;
   assign rsp_was_clamped    = rsp_clamped_ff;

endmodule

FILE: verif/preamble_qualified_serial_receiver_core_test.sv
// ----------------------------------------------------------------------------
// preamble_qualified_serial_receiver_core_test
// self-checking bench for the preamble-qualified serial receiver
// ----------------------------------------------------------------------------
// Line samples are queued by a stimulus process and handed to the block one
// request per cycle, unless stalled, by a clocked driver, which also runs a
// cycle-free model of the receiver on every accepted request and queues the
// frame it should report. A clocked monitor pops that queue for every
// accepted response and compares both fields. The run starts on the reset
// register values, then walks through zero, minimum and maximum timing,
// limits of 0 and 511 and a run of random settings with well-formed, aborted
// and noisy frames, while both sides insert random idle bursts.
// ----------------------------------------------------------------------------
module preamble_qualified_serial_receiver_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pqsr_pkg::*;

   localparam int FRAME_BITS     = DATA_BITS_DEFAULT;
   localparam int IDLE_LIMIT     = 2000;  // cycles with no traffic before giving up
   localparam int SETTLE_CYCLES  = 8;     // response register plus margin
   localparam int DRAIN_CYCLES   = 30;
   localparam int RANDOM_SAMPLES = 1400;
   localparam int RANDOM_FRAMES  = 30;
   localparam int PHASE_SAMPLES  = 250;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               clamped;
   } frame_word_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   // block ports, inputs all known from time zero
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic                  req_line_level = 1'b1;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [VALUE_W-1:0]    rsp_received_value;
   logic                  rsp_was_clamped;
   logic                  psel           = 1'b0;
   logic                  penable        = 1'b0;
   logic                  pwrite         = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr          = '0;
   logic [CSR_DATA_W-1:0] pwdata         = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   preamble_qualified_serial_receiver_core dut (.*);

   // ------------------------------------------------------------------------
   // receiver model: register copy and frame state
   // ------------------------------------------------------------------------
   config_type              rx_regs  = {PREAMBLE_RESET, OFFSET_RESET, PERIOD_RESET,
                                        LIMIT_RESET};
   phase_type               rx_phase = PH_IDLE;
   logic [TICK_W-1:0]       rx_ticks = '0;
   logic [3:0]              rx_bit   = '0;
   logic [FRAME_BITS-1:0]   rx_shift = '0;
   logic                    rx_prev  = 1'b1;  // high out of reset, so no false edge

   frame_word_type          pending_frames[$];  // frames the block still owes us
   logic                    line_samples[$];    // samples not yet handed to the driver

   // bookkeeping
   int samples_queued = 0;
   int samples_taken  = 0;
   int frames_sent    = 0;
   int frames_checked = 0;
   int clamped_seen   = 0;
   int settings_used  = 0;
   int mismatches     = 0;
   int quiet_cycles   = 0;

   // idle knobs, percent chance per cycle of starting a burst
   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int send_gap_left  = 0;
   int recv_stall_left = 0;

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // one step of a timing counter; a span of zero behaves as one
   function automatic logic tick_elapsed(input logic [TICK_W-1:0] span);
      rx_ticks = rx_ticks + 1'b1;
      if (rx_ticks >= span || rx_ticks == '0) begin
         rx_ticks = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // advance the model by one line sample, queueing any frame it completes
   function automatic void advance_receiver(input logic level);
      frame_word_type done;
      case (rx_phase)
         PH_QUALIFY: begin
            // any low sample during qualification drops back to idle
            if (!level)
               rx_phase = PH_IDLE;
            else if (tick_elapsed(rx_regs.preamble_ticks))
               rx_phase = PH_WAITLOW;
         end
         PH_WAITLOW: begin
            // no timeout here, the start level may take forever
            if (!level) begin
               rx_phase = PH_OFFSET;
               rx_ticks = '0;
               rx_shift = '0;
            end
         end
         PH_OFFSET: begin
            if (tick_elapsed(rx_regs.sample_offset_ticks)) begin
               rx_bit      = '0;
               rx_shift[0] = level;
               rx_phase    = PH_BITS;
            end
         end
         PH_BITS: begin
            if (tick_elapsed(rx_regs.bit_period_ticks)) begin
               if (int'(rx_bit) + 1 < FRAME_BITS) begin
                  rx_bit           = rx_bit + 1'b1;
                  rx_shift[rx_bit] = level;
               end else begin
                  // the emitting sample itself is not looked at for an edge
                  done.clamped = rx_shift > rx_regs.value_limit;
                  done.value   = done.clamped ? rx_regs.value_limit : rx_shift;
                  pending_frames.push_back(done);
                  rx_phase = PH_IDLE;
               end
            end
         end
         default: begin
            rx_phase = PH_IDLE;
            if (level && !rx_prev) begin
               rx_phase = PH_QUALIFY;
               rx_ticks = '0;
            end
         end
      endcase
      rx_prev = level;
   endfunction

   // ------------------------------------------------------------------------
   // request driver: one line sample per request, random idle bursts
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : sample_driver
      logic held;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         held = req_valid && req_stall;
         if (req_valid && !req_stall) begin
            advance_receiver(req_line_level);
            samples_taken++;
         end
         // a stalled request keeps its payload untouched
         if (!held) begin
            if (send_gap_left > 0) begin
               send_gap_left--;
               req_valid <= 1'b0;
            end else if (line_samples.size() != 0 && send_gap_pct != 0 &&
                         $urandom_range(99) < send_gap_pct) begin
               send_gap_left = $urandom_range(16);
               req_valid <= 1'b0;
            end else if (line_samples.size() != 0) begin
               req_valid      <= 1'b1;
               req_line_level <= line_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // response monitor: field by field against the oldest queued frame
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : frame_monitor
      frame_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_frames.size() == 0) begin
               flag_mismatch($sformatf("frame %0d/%0b with none outstanding",
                                       rsp_received_value, rsp_was_clamped));
            end else begin
               want = pending_frames.pop_front();
               if (rsp_received_value !== want.value)
                  flag_mismatch($sformatf("received_value %0d, wanted %0d",
                                          rsp_received_value, want.value));
               if (rsp_was_clamped !== want.clamped)
                  flag_mismatch($sformatf("was_clamped %0b, wanted %0b",
                                          rsp_was_clamped, want.clamped));
               frames_checked++;
               if (want.clamped)
                  clamped_seen++;
            end
         end
         if (recv_stall_left > 0) begin
            recv_stall_left--;
            rsp_stall <= 1'b1;
         end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
            recv_stall_left = $urandom_range(16);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: too long without any request, response or register access
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_level(input logic level);
      line_samples.push_back(level);
      samples_queued++;
   endtask

   function automatic int span_of(input logic [TICK_W-1:0] span);
      return (span == '0) ? 1 : int'(span);
   endfunction

   // well-formed or aborted frame; expects the receiver to be idle
   task automatic push_frame(input logic [FRAME_BITS-1:0] word, input logic abort,
                             input logic closing);
      int pre;
      int off;
      int per;
      pre = span_of(rx_regs.preamble_ticks);
      off = span_of(rx_regs.sample_offset_ticks);
      per = span_of(rx_regs.bit_period_ticks);
      repeat ($urandom_range(3, 1)) push_level(1'b0);
      push_level(1'b1);  // rising edge
      if (abort) begin
         // drop the line before the preamble has run out
         repeat ($urandom_range(pre - 1)) push_level(1'b1);
         push_level(1'b0);
      end else begin
         repeat (pre) push_level(1'b1);
         repeat ($urandom_range(3)) push_level(1'b1);  // dwell before the start level
         push_level(1'b0);
         // filler between sample points is random, so edges land in every phase
         for (int i = 0; i <= FRAME_BITS; i++) begin
            repeat (((i == 0) ? off : per) - 1) push_level(1'($urandom_range(1)));
            if (i < FRAME_BITS)
               push_level(word[i]);
            else
               push_level(closing);
         end
         frames_sent++;
      end
   endtask

   // wait for the queue to empty, then pull the receiver back to idle with lows
   task automatic settle_line();
      while (samples_taken != samples_queued) @(posedge clock);
      while (rx_phase != PH_IDLE) begin
         push_level(1'b0);
         while (samples_taken != samples_queued) @(posedge clock);
      end
   endtask

   // sender holds off until every owed frame is back and the block is quiet
   task automatic wait_for_quiet();
      settle_line();
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write followed by a read back of the same register
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [TICK_W-1:0] word);
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] seen;
      mask = (idx == CSR_LIMIT) ? CSR_DATA_W'({VALUE_W{1'b1}}) : CSR_DATA_W'({TICK_W{1'b1}});
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= CSR_DATA_W'(word);
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (pready !== 1'b1);
      @(posedge clock);
      case (idx)
         CSR_PREAMBLE: rx_regs.preamble_ticks      = word;
         CSR_OFFSET:   rx_regs.sample_offset_ticks = word;
         CSR_PERIOD:   rx_regs.bit_period_ticks    = word;
         CSR_LIMIT:    rx_regs.value_limit         = word[VALUE_W-1:0];
         default: ;
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (pready !== 1'b1);
      seen = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if ((seen & mask) !== (CSR_DATA_W'(word) & mask))
         flag_mismatch($sformatf("register %0d reads %0h, wrote %0h", idx, seen, word));
   endtask

   task automatic program_timing(input logic [TICK_W-1:0] preamble,
                                 input logic [TICK_W-1:0] offset,
                                 input logic [TICK_W-1:0] period,
                                 input logic [VALUE_W-1:0] limit);
      wait_for_quiet();
      write_register(CSR_PREAMBLE, preamble);
      write_register(CSR_OFFSET, offset);
      write_register(CSR_PERIOD, period);
      write_register(CSR_LIMIT, TICK_W'(limit));
      settings_used++;
   endtask

   // mostly short spans so frames stay brief, now and then zero
   function automatic logic [TICK_W-1:0] pick_span(input int top);
      return ($urandom_range(9) == 0) ? '0 : TICK_W'($urandom_range(top, 1));
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int random_start;
      int frames_start;
      int phase_start;
      int roll;
      logic [VALUE_W-1:0] limit;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset register values; line high straight out of reset is not an edge
      send_gap_pct   = 10;
      recv_stall_pct = 10;
      push_level(1'b1);
      push_level(1'b1);
      push_frame(FRAME_BITS'($urandom_range(511)), 1'b1, 1'b0);
      settings_used++;

      // timing registers written as zero act as one, limit of zero
      program_timing('0, '0, '0, '0);
      push_frame('0, 1'b0, 1'b0);
      push_frame('1, 1'b0, 1'b1);
      push_frame(FRAME_BITS'(1), 1'b0, 1'b0);
      push_frame('0, 1'b1, 1'b0);

      // shortest legal timing, full limit
      program_timing(TICK_W'(1), TICK_W'(1), TICK_W'(1), '1);
      push_frame('1, 1'b0, 1'b0);
      push_frame(FRAME_BITS'('h155), 1'b0, 1'b0);
      // last bit low, emitting sample high: that rise must not start a frame
      push_frame(FRAME_BITS'('h0aa), 1'b0, 1'b1);
      push_level(1'b1);
      push_frame('0, 1'b0, 1'b0);
      push_frame('0, 1'b1, 1'b0);

      // longest timing on every register, qualification cut short
      program_timing('1, '1, '1, VALUE_W'(300));
      send_gap_pct   = 1;
      recv_stall_pct = 1;
      push_level(1'b0);
      push_level(1'b1);
      repeat (20) push_level(1'b1);
      push_level(1'b0);

      // random settings with mostly well-formed frames, some aborts and noise
      random_start = samples_queued;
      frames_start = frames_sent;
      while (samples_queued - random_start < RANDOM_SAMPLES ||
             frames_sent - frames_start < RANDOM_FRAMES) begin
         case ($urandom_range(3))
            0:       limit = '0;
            1:       limit = '1;
            default: limit = VALUE_W'($urandom_range(511));
         endcase
         program_timing(pick_span(6), pick_span(6), pick_span(4), limit);
         // the closing stretch runs with neither side idling
         if (samples_queued - random_start > RANDOM_SAMPLES * 4 / 5) begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end else begin
            send_gap_pct   = $urandom_range(2) * 6;
            recv_stall_pct = $urandom_range(2) * 6;
         end
         phase_start = samples_queued;
         while (samples_queued - phase_start < PHASE_SAMPLES) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
               push_frame(FRAME_BITS'($urandom_range(511)), 1'b0, 1'($urandom_range(1)));
            end else if (roll < 85) begin
               push_frame(FRAME_BITS'($urandom_range(511)), 1'b1, 1'b0);
            end else begin
               // raw noise can start, abort or finish frames of its own
               repeat ($urandom_range(40, 1)) push_level(1'($urandom_range(1)));
               settle_line();
            end
            if ($urandom_range(15) == 0)
               wait_for_quiet();
         end
      end

      wait_for_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d line samples over %0d register settings", samples_taken,
               settings_used);
      $display("checked %0d frames, %0d of them clamped", frames_checked, clamped_seen);
      if (mismatches == 0 && pending_frames.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: preamble_qualified_serial_receiver_core.f
sv/pqsr_pkg.sv
sv/pqsr_csr.sv
sv/pqsr_fsm.sv
sv/preamble_qualified_serial_receiver_core.sv
verif/preamble_qualified_serial_receiver_core_test.sv
